### rtl/core/bleadv_pkg.sv
package bleadv_pkg;

  localparam int MaxDevicesDef = 32;
  localparam int NameBytesDef  = 32;

  localparam logic [7:0] TypeFullName  = 8'h09;
  localparam logic [7:0] TypeShortName = 8'h08;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_UPDATED = 3'd0,
    OUT_ADDED   = 3'd1,
    OUT_DROPPED = 3'd2,
    OUT_READ    = 3'd3,
    OUT_CLEARED = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_BODY = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // latch input beat, run parser
    logic search_clr;  // start a new address search
    logic search_step; // compare one slot
    logic commit;      // write table for the report
    logic copy_step;   // copy one name character
    logic read_issue;  // register read of the selected entry
    logic clear;       // drop table count
    logic out_load;    // load result register
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic search_done;
    logic copy_done;
    logic need_copy;
  } sts_t;

endpackage

### rtl/core/bleadv_ctrl.sv
module bleadv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_cmd,
  input  logic            in_report_end,
  input  logic            out_valid,
  input  logic            out_ready,
  input  bleadv_pkg::sts_t sts,
  output bleadv_pkg::ctl_t ctl
);
  import bleadv_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_COMMIT = 7'b0000100,
    S_COPY   = 7'b0001000,
    S_READ   = 7'b0010000,
    S_RESULT = 7'b0100000,
    S_CLEAR  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_free;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.take = 1'b1;
          ctl.search_clr = 1'b1;
          unique case (in_cmd)
            CMD_DATA:  if (in_report_end) state_nxt = S_SEARCH;
            CMD_READ:  state_nxt = S_READ;
            CMD_CLEAR: state_nxt = S_CLEAR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        ctl.search_step = 1'b1;
        if (sts.search_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          ctl.out_load = 1'b1;
          state_nxt = sts.need_copy ? S_COPY : S_IDLE;
        end
      end
      S_COPY: begin
        ctl.copy_step = 1'b1;
        if (sts.copy_done) state_nxt = S_IDLE;
      end
      S_READ: begin
        ctl.read_issue = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (out_free) begin
          ctl.clear = 1'b1;
          ctl.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // only one control strobe per cycle that touches the table
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.commit, ctl.copy_step, ctl.read_issue, ctl.clear}))
    else $error("table strobes overlap");
  // a beat is taken only when idle
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |-> (state_r == S_IDLE))
    else $error("beat taken while busy");
  // commit always follows a finished search
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |-> ($past(state_r) == S_SEARCH || $past(state_r) == S_COMMIT))
    else $error("commit without search");
endmodule

### rtl/core/bleadv_dp.sv
module bleadv_dp #(
  parameter int MAX_DEVICES = bleadv_pkg::MaxDevicesDef,
  parameter int NAME_BYTES  = bleadv_pkg::NameBytesDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bleadv_pkg::ctl_t ctl,
  output bleadv_pkg::sts_t sts,
  input  logic [1:0]       in_cmd,
  input  logic [47:0]      in_device_address,
  input  logic [1:0]       in_addr_kind,
  input  logic signed [7:0] in_signal_strength,
  input  logic [31:0]      in_timestamp,
  input  logic [7:0]       in_data_byte,
  input  logic             in_byte_present,
  input  logic [4:0]       in_entry_select,
  input  logic [4:0]       in_char_select,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [2:0]       out_outcome,
  output logic [4:0]       out_slot,
  output logic [5:0]       out_entry_total,
  output logic             out_name_stored,
  output logic [47:0]      out_entry_address,
  output logic [1:0]       out_entry_addr_kind,
  output logic signed [7:0] out_entry_strength,
  output logic [31:0]      out_entry_seen,
  output logic             out_entry_named,
  output logic [4:0]       out_entry_name_length,
  output logic [7:0]       out_entry_name_char,
  output logic             out_entry_valid
);
  import bleadv_pkg::*;

  localparam int SW  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CW  = $clog2(MAX_DEVICES + 1);
  localparam int NW  = $clog2(NAME_BYTES);
  localparam int NS  = 1 << NW;
  localparam int NL  = NAME_BYTES - 1;
  localparam int MW  = SW + NW;

  // table stores
  logic [47:0] addr_mem   [MAX_DEVICES];
  logic [1:0]  kind_mem   [MAX_DEVICES];
  logic [7:0]  rssi_mem   [MAX_DEVICES];
  logic [31:0] seen_mem   [MAX_DEVICES];
  logic        named_mem  [MAX_DEVICES];
  logic [4:0]  nlen_mem   [MAX_DEVICES];
  logic [7:0]  char_mem   [MAX_DEVICES * NS];
  logic [7:0]  pend_mem   [NAME_BYTES];

  logic [CW-1:0] count_r;
  logic [7:0]    pos_r;
  logic [8:0]    fend_r;
  phase_t        phase_r;
  logic [NW-1:0] plen_r;
  logic [1:0]    pflags_r;

  // latched beat
  logic [47:0] addr_r;
  logic [1:0]  kind_r;
  logic [7:0]  rssi_r;
  logic [31:0] tick_r;
  logic [4:0]  esel_r, csel_r;
  logic [1:0]  cmd_r;

  // search
  logic [CW-1:0] sidx_r;
  logic          found_r;
  logic [SW-1:0] fslot_r;
  logic          sdone_r;

  // name copy
  logic [SW-1:0] cslot_r;
  logic [NW-1:0] cidx_r;
  logic [NW-1:0] clen_r;
  logic          namecp_r;
  logic [NW-1:0] pidx;

  // read pipe
  logic [47:0] rd_addr_r;
  logic [1:0]  rd_kind_r;
  logic [7:0]  rd_rssi_r;
  logic [31:0] rd_seen_r;
  logic        rd_named_r;
  logic [4:0]  rd_nlen_r;
  logic [7:0]  rd_char_r;
  logic [7:0]  pend_rd_r;

  logic [7:0]  b;
  logic [8:0]  p9;
  logic        is_name;

  assign b = in_data_byte;
  assign p9 = {1'b0, pos_r};
  assign is_name = (b == TypeFullName) || (b == TypeShortName);

  // parser and beat latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fend_r <= '0;
      phase_r <= PH_LEN;
      plen_r <= '0;
      pflags_r <= '0;
    end else if (ctl.take && in_cmd == CMD_DATA && in_byte_present && pos_r != 8'd255) begin
      pos_r <= pos_r + 8'd1;
      unique case (phase_r)
        PH_LEN: begin
          if (b == 8'd0) begin
            phase_r <= PH_STOP;
          end else begin
            fend_r <= p9 + {1'b0, b};
            phase_r <= PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (is_name) begin
            plen_r <= '0;
            if (p9 == fend_r) begin
              pflags_r <= 2'b11;
              phase_r <= PH_STOP;
            end else begin
              pflags_r <= 2'b01;
              phase_r <= PH_BODY;
            end
          end else begin
            phase_r <= (p9 == fend_r) ? PH_LEN : PH_BODY;
          end
        end
        PH_BODY: begin
          if (pflags_r[0]) begin
            if (32'(plen_r) < NL) plen_r <= plen_r + 1'b1;
            if (p9 == fend_r) begin
              pflags_r <= pflags_r | 2'b10;
              phase_r <= PH_STOP;
            end
          end else if (p9 == fend_r) begin
            phase_r <= PH_LEN;
          end
        end
        default: phase_r <= phase_r;
      endcase
    end else if (ctl.commit) begin
      pos_r <= '0;
      fend_r <= '0;
      phase_r <= PH_LEN;
      plen_r <= '0;
      pflags_r <= '0;
    end
  end

  // pending name buffer; read one character ahead of the copy write
  assign pidx = cidx_r + NW'(namecp_r);
  always_ff @(posedge clk) begin
    if (ctl.take && in_cmd == CMD_DATA && in_byte_present && pos_r != 8'd255 &&
        phase_r == PH_BODY && pflags_r[0] && 32'(plen_r) < NL) begin
      pend_mem[plen_r] <= b;
    end
    pend_rd_r <= pend_mem[pidx];
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      addr_r <= in_device_address;
      kind_r <= in_addr_kind;
      rssi_r <= in_signal_strength;
      tick_r <= in_timestamp;
      esel_r <= in_entry_select;
      csel_r <= in_char_select;
      cmd_r  <= in_cmd;
    end
  end

  // address search, one slot a cycle
  logic [47:0] srd_r;
  logic        sval_r;
  logic [SW-1:0] sprev_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidx_r <= '0; found_r <= 1'b0; sval_r <= 1'b0; sdone_r <= 1'b0;
    end else if (ctl.search_clr) begin
      sidx_r <= '0; found_r <= 1'b0; sval_r <= 1'b0; sdone_r <= 1'b0;
    end else if (ctl.search_step) begin
      if (sval_r && !found_r && srd_r == addr_r) begin
        found_r <= 1'b1;
        fslot_r <= sprev_r;
      end
      sval_r <= (sidx_r < count_r);
      sprev_r <= sidx_r[SW-1:0];
      if (sidx_r < count_r) sidx_r <= sidx_r + 1'b1;
      sdone_r <= !(sidx_r < count_r) && !sval_r;
    end
  end
  always_ff @(posedge clk) begin
    srd_r <= addr_mem[sidx_r[SW-1:0]];
  end
  assign sts.search_done = sdone_r || (found_r && ctl.search_step);

  // commit decision
  logic          full;
  logic [SW-1:0] tslot;
  logic          name_ok;
  logic          do_name;
  assign full    = (32'(count_r) >= MAX_DEVICES);
  assign tslot   = found_r ? fslot_r : count_r[SW-1:0];
  assign name_ok = pflags_r[1];
  assign do_name = name_ok && (found_r ? !named_mem[fslot_r] : !full);
  assign sts.need_copy = do_name && (plen_r != '0);

  // table writes
  always_ff @(posedge clk) begin
    if (ctl.commit && (found_r || !full)) begin
      rssi_mem[tslot] <= rssi_r;
      seen_mem[tslot] <= tick_r;
      if (!found_r) begin
        addr_mem[tslot] <= addr_r;
        kind_mem[tslot] <= kind_r;
        named_mem[tslot] <= 1'b0;
        nlen_mem[tslot] <= '0;
      end
      if (do_name) begin
        named_mem[tslot] <= 1'b1;
        nlen_mem[tslot] <= 5'(plen_r);
      end
    end
  end

  // name copy, one character a cycle, each written from a registered read of the pending buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      namecp_r <= 1'b0;
      cidx_r <= '0;
    end else if (ctl.commit) begin
      cslot_r <= tslot;
      clen_r <= plen_r;
      cidx_r <= '0;
      namecp_r <= 1'b0;
    end else if (ctl.copy_step) begin
      namecp_r <= 1'b1;
      if (namecp_r) cidx_r <= cidx_r + 1'b1;
    end
  end
  logic [NW-1:0] widx;
  assign widx = cidx_r;
  always_ff @(posedge clk) begin
    if (ctl.copy_step && namecp_r) begin
      char_mem[MW'({cslot_r, widx})] <= pend_rd_r;
    end
  end
  assign sts.copy_done = namecp_r && (cidx_r + 1'b1 == clen_r);

  // count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clear) begin
      count_r <= '0;
    end else if (ctl.commit && !found_r && !full) begin
      count_r <= count_r + 1'b1;
    end
  end

  // entry read
  logic [SW-1:0] rsl;
  logic [NW-1:0] rch;
  assign rsl = SW'(esel_r);
  assign rch = NW'(csel_r);
  always_ff @(posedge clk) begin
    if (ctl.read_issue) begin
      rd_addr_r  <= addr_mem[rsl];
      rd_kind_r  <= kind_mem[rsl];
      rd_rssi_r  <= rssi_mem[rsl];
      rd_seen_r  <= seen_mem[rsl];
      rd_named_r <= named_mem[rsl];
      rd_nlen_r  <= nlen_mem[rsl];
      rd_char_r  <= char_mem[MW'({rsl, rch})];
    end
  end

  logic rvalid, cvalid;
  assign rvalid = (32'(esel_r) < 32'(count_r)) && (32'(esel_r) < MAX_DEVICES);
  assign cvalid = rd_named_r && (csel_r < rd_nlen_r) && (32'(csel_r) < NL);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_name_stored <= 1'b0;
      out_entry_address <= '0;
      out_entry_addr_kind <= '0;
      out_entry_strength <= '0;
      out_entry_seen <= '0;
      out_entry_named <= 1'b0;
      out_entry_name_length <= '0;
      out_entry_name_char <= '0;
      out_entry_valid <= 1'b0;
      out_slot <= '0;
      out_entry_total <= 6'(count_r);
      if (ctl.clear) begin
        out_outcome <= OUT_CLEARED;
        out_entry_total <= '0;
      end else if (ctl.commit) begin
        out_name_stored <= do_name;
        if (found_r) begin
          out_outcome <= OUT_UPDATED;
          out_slot <= 5'(fslot_r);
        end else if (!full) begin
          out_outcome <= OUT_ADDED;
          out_slot <= 5'(count_r);
          out_entry_total <= 6'(count_r + 1'b1);
        end else begin
          out_outcome <= OUT_DROPPED;
        end
      end else begin
        out_outcome <= OUT_READ;
        out_slot <= esel_r;
        if (rvalid) begin
          out_entry_valid <= 1'b1;
          out_entry_address <= rd_addr_r;
          out_entry_addr_kind <= rd_kind_r;
          out_entry_strength <= rd_rssi_r;
          out_entry_seen <= rd_seen_r;
          out_entry_named <= rd_named_r;
          out_entry_name_length <= rd_nlen_r;
          out_entry_name_char <= cvalid ? rd_char_r : 8'd0;
        end
      end
    end
  end

  // count never exceeds the table size
  assert property (@(posedge clk) disable iff (!rst_n) 32'(count_r) <= MAX_DEVICES)
    else $error("count overflow");
  // a commit with a table hit never grows the count
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && found_r) |=> $stable(count_r))
    else $error("hit grew count");
  // the loaded result holds while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && !ctl.out_load) |=> $stable(out_outcome))
    else $error("result changed under stall");
  // an entry read is issued only for a read beat
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.read_issue |-> (cmd_r == CMD_READ))
    else $error("read without read command");
endmodule

### rtl/core/ble_adv_device_table.sv
// Channel  Handshake             Payload
// in       in_valid/in_ready     cmd, address, kind, rssi, tick, byte, flags, selects
// out      out_valid/out_ready   outcome, slot, total, name flag, entry fields
// A data beat that is not the report's last is taken while idle and leaves the block idle.
// A report's last beat runs accept, a slot-by-slot search of the address store, then
// commit; a new name of nonzero length adds a character copy after the commit.
// A read registers the entry, then loads the result; a clear loads its own result.
// Reset (rst_n low, synchronous) empties the table and restarts the parser.
// A stalled result register holds the block before its next commit, read result or clear.
module ble_adv_device_table #(
  parameter int MAX_DEVICES = bleadv_pkg::MaxDevicesDef,
  parameter int NAME_BYTES  = bleadv_pkg::NameBytesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [47:0]       in_device_address,
  input  logic [1:0]        in_addr_kind,
  input  logic signed [7:0] in_signal_strength,
  input  logic [31:0]       in_timestamp,
  input  logic [7:0]        in_data_byte,
  input  logic              in_byte_present,
  input  logic              in_report_end,
  input  logic [4:0]        in_entry_select,
  input  logic [4:0]        in_char_select,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_outcome,
  output logic [4:0]        out_slot,
  output logic [5:0]        out_entry_total,
  output logic              out_name_stored,
  output logic [47:0]       out_entry_address,
  output logic [1:0]        out_entry_addr_kind,
  output logic signed [7:0] out_entry_strength,
  output logic [31:0]       out_entry_seen,
  output logic              out_entry_named,
  output logic [4:0]        out_entry_name_length,
  output logic [7:0]        out_entry_name_char,
  output logic              out_entry_valid
);
  import bleadv_pkg::*;

  ctl_t ctl;
  sts_t sts;

  bleadv_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_report_end,
    .out_valid, .out_ready, .sts, .ctl
  );

  bleadv_dp #(.MAX_DEVICES(MAX_DEVICES), .NAME_BYTES(NAME_BYTES)) u_dp (
    .clk, .rst_n, .ctl, .sts, .in_cmd, .in_device_address, .in_addr_kind,
    .in_signal_strength, .in_timestamp, .in_data_byte, .in_byte_present,
    .in_entry_select, .in_char_select, .out_ready, .out_valid, .out_outcome,
    .out_slot, .out_entry_total, .out_name_stored, .out_entry_address,
    .out_entry_addr_kind, .out_entry_strength, .out_entry_seen, .out_entry_named,
    .out_entry_name_length, .out_entry_name_char, .out_entry_valid
  );
endmodule

### bench/ble_adv_device_table_tb.sv
module ble_adv_device_table_tb;
  import bleadv_pkg::*;

  localparam int NumDev    = MaxDevicesDef;
  localparam int NameMax   = NameBytesDef - 1;
  localparam int CycleCap  = 2000000;
  localparam int RandItems = 1100;

  typedef struct {
    cmd_t             cmd;
    logic [47:0]      addr;
    logic [1:0]       kind;
    logic signed [7:0] rssi;
    logic [31:0]      tick;
    logic [7:0]       data;
    logic             present;
    logic             last;
    logic [4:0]       esel;
    logic [4:0]       csel;
  } beat_t;

  typedef struct {
    outcome_t          outcome;
    logic [4:0]        slot;
    logic [5:0]        total;
    logic              name_stored;
    logic [47:0]       e_addr;
    logic [1:0]        e_kind;
    logic signed [7:0] e_rssi;
    logic [31:0]       e_seen;
    logic              e_named;
    logic [4:0]        e_len;
    logic [7:0]        e_char;
    logic              e_valid;
  } table_result_t;

  typedef logic [47:0] pool_addr_t[48];

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] in_cmd, in_addr_kind;
  logic [47:0] in_device_address;
  logic signed [7:0] in_signal_strength;
  logic [31:0] in_timestamp;
  logic [7:0] in_data_byte;
  logic in_byte_present, in_report_end;
  logic [4:0] in_entry_select, in_char_select;
  logic [2:0] out_outcome;
  logic [4:0] out_slot;
  logic [5:0] out_entry_total;
  logic out_name_stored;
  logic [47:0] out_entry_address;
  logic [1:0] out_entry_addr_kind;
  logic signed [7:0] out_entry_strength;
  logic [31:0] out_entry_seen;
  logic out_entry_named;
  logic [4:0] out_entry_name_length;
  logic [7:0] out_entry_name_char;
  logic out_entry_valid;

  ble_adv_device_table u_top (.*);

  // shadow of the device table and the AD parser
  logic [47:0] tbl_addr [NumDev];
  logic [1:0]  tbl_kind [NumDev];
  logic [7:0]  tbl_rssi [NumDev];
  logic [31:0] tbl_seen [NumDev];
  logic        tbl_named[NumDev];
  logic [4:0]  tbl_len  [NumDev];
  logic [7:0]  tbl_name [NumDev][NameBytesDef];
  int          dev_count;
  int          byte_pos, field_stop, pend_len;
  phase_t      phase;
  bit          name_begun, name_done;
  logic [7:0]  name_buf[NameBytesDef];

  table_result_t expected_q[$];
  int  errors, cycles, reports_sent, reads_sent, results_seen, items_sent;
  bit  no_gaps;
  pool_addr_t pool;

  function automatic void parse_restart();
    byte_pos = 0; field_stop = 0; phase = PH_LEN; pend_len = 0;
    name_begun = 0; name_done = 0;
  endfunction

  // advance the AD structure walker by one byte
  function automatic void parse_byte(logic [7:0] b);
    int p;
    p = byte_pos;
    if (p >= 255) return;
    byte_pos = p + 1;
    case (phase)
      PH_LEN: begin
        if (b == 0) phase = PH_STOP;
        else begin
          field_stop = p + b;
          phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (b == TypeFullName || b == TypeShortName) begin
          name_begun = 1; name_done = 0; pend_len = 0;
          if (p == field_stop) begin
            name_done = 1; phase = PH_STOP;
          end else phase = PH_BODY;
        end else phase = (p == field_stop) ? PH_LEN : PH_BODY;
      end
      PH_BODY: begin
        if (name_begun) begin
          if (pend_len < NameMax) begin
            name_buf[pend_len] = b;
            pend_len++;
          end
          if (p == field_stop) begin
            name_done = 1; phase = PH_STOP;
          end
        end else if (p == field_stop) phase = PH_LEN;
      end
      default: ;
    endcase
  endfunction

  function automatic void store_name(int s);
    for (int i = 0; i < pend_len; i++) tbl_name[s][i] = name_buf[i];
    tbl_len[s] = 5'(pend_len);
    tbl_named[s] = 1;
  endfunction

  // expected result of one accepted beat; returns 0 when none is due
  function automatic bit table_predict(beat_t b, output table_result_t r);
    int found;
    r = '{OUT_UPDATED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    case (b.cmd)
      CMD_DATA: begin
        if (b.present) parse_byte(b.data);
        if (!b.last) return 0;
        found = dev_count;
        for (int i = 0; i < dev_count; i++)
          if (tbl_addr[i] == b.addr) begin
            found = i;
            break;
          end
        if (found < dev_count) begin
          tbl_rssi[found] = b.rssi;
          tbl_seen[found] = b.tick;
          if (!tbl_named[found] && name_done) begin
            store_name(found);
            r.name_stored = 1;
          end
          r.slot = 5'(found);
        end else if (dev_count < NumDev) begin
          tbl_addr[dev_count] = b.addr;
          tbl_kind[dev_count] = b.kind;
          tbl_rssi[dev_count] = b.rssi;
          tbl_seen[dev_count] = b.tick;
          tbl_named[dev_count] = 0;
          tbl_len[dev_count] = 0;
          if (name_done) begin
            store_name(dev_count);
            r.name_stored = 1;
          end
          r.outcome = OUT_ADDED;
          r.slot = 5'(dev_count);
          dev_count++;
        end else r.outcome = OUT_DROPPED;
        r.total = 6'(dev_count);
        parse_restart();
        return 1;
      end
      CMD_READ: begin
        r.outcome = OUT_READ;
        r.slot = b.esel;
        r.total = 6'(dev_count);
        if (b.esel < dev_count) begin
          r.e_addr = tbl_addr[b.esel];
          r.e_kind = tbl_kind[b.esel];
          r.e_rssi = tbl_rssi[b.esel];
          r.e_seen = tbl_seen[b.esel];
          r.e_named = tbl_named[b.esel];
          r.e_len = tbl_len[b.esel];
          if (tbl_named[b.esel] && b.csel < tbl_len[b.esel] && b.csel < NameMax)
            r.e_char = tbl_name[b.esel][b.csel];
          r.e_valid = 1;
        end
        return 1;
      end
      CMD_CLEAR: begin
        dev_count = 0;
        r.outcome = OUT_CLEARED;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // clock, cycle limit
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // result side: random backpressure, stretches without stalls
  initial begin
    int run, mode;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      run = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      repeat (run) begin
        @(posedge clk);
        if (mode == 0) out_ready <= 1;
        else out_ready <= ($urandom_range(0, 99) < (mode == 3 ? 20 : 70));
      end
    end
  end

  task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, fname, exp_v, act_v);
      errors++;
    end
  endtask

  // compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    table_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result beat, outcome %0d", $time, out_outcome);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("outcome", e.outcome, out_outcome);
        check_field("slot", e.slot, out_slot);
        check_field("entry_total", e.total, out_entry_total);
        check_field("name_stored", e.name_stored, out_name_stored);
        check_field("entry_address", e.e_addr, out_entry_address);
        check_field("entry_addr_kind", e.e_kind, out_entry_addr_kind);
        check_field("entry_strength", e.e_rssi, out_entry_strength);
        check_field("entry_seen", e.e_seen, out_entry_seen);
        check_field("entry_named", e.e_named, out_entry_named);
        check_field("entry_name_length", e.e_len, out_entry_name_length);
        check_field("entry_name_char", e.e_char, out_entry_name_char);
        check_field("entry_valid", e.e_valid, out_entry_valid);
      end
    end
  end

  // drive one beat, hold until accepted, then predict
  task automatic send_beat(beat_t b);
    table_result_t r;
    int gap;
    in_valid <= 1;
    in_cmd <= b.cmd;
    in_device_address <= b.addr;
    in_addr_kind <= b.kind;
    in_signal_strength <= b.rssi;
    in_timestamp <= b.tick;
    in_data_byte <= b.data;
    in_byte_present <= b.present;
    in_report_end <= b.last;
    in_entry_select <= b.esel;
    in_char_select <= b.csel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (table_predict(b, r)) expected_q.push_back(r);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic beat_t rand_beat(cmd_t c);
    beat_t b;
    b.cmd = c;
    b.addr = 48'({$urandom(), $urandom()});
    b.kind = 2'($urandom());
    b.rssi = 8'($urandom());
    b.tick = $urandom();
    b.data = 8'($urandom());
    b.present = 1'($urandom());
    b.last = 1'($urandom());
    b.esel = 5'($urandom());
    b.csel = 5'($urandom());
    return b;
  endfunction

  task automatic send_read(int esel, int csel);
    beat_t b;
    b = rand_beat(CMD_READ);
    b.esel = 5'(esel);
    b.csel = 5'(csel);
    reads_sent++;
    send_beat(b);
  endtask

  // one report; an empty byte list sends a report without data
  task automatic send_report(logic [47:0] addr, logic [1:0] kind, logic [7:0] rssi,
                             logic [31:0] tick, logic [7:0] ad[$], bit interleave);
    beat_t b;
    int n;
    n = ad.size();
    b = rand_beat(CMD_DATA);
    b.kind = kind; b.rssi = rssi; b.tick = tick;
    if (n == 0) begin
      b.addr = addr; b.present = 0; b.last = 1;
      send_beat(b);
    end
    for (int i = 0; i < n; i++) begin
      b.addr = ($urandom_range(0, 19) == 0 && i != n - 1) ?
               48'({$urandom(), $urandom()}) : addr;
      b.data = ad[i];
      b.present = 1;
      b.last = (i == n - 1);
      // an idle data beat inside the report
      if (interleave && $urandom_range(0, 29) == 0 && !b.last) begin
        b.present = 0;
        send_beat(b);
        b.present = 1;
      end
      send_beat(b);
      // commands in the middle of a report
      if (interleave && !b.last && $urandom_range(0, 39) == 0) begin
        if ($urandom_range(0, 9) == 0) send_beat(rand_beat(CMD_CLEAR));
        else send_read($urandom_range(0, 31), $urandom_range(0, 31));
      end
    end
    reports_sent++;
  endtask

  task automatic add_name(ref logic [7:0] ad[$], input logic [7:0] tcode, input int chars);
    ad.push_back(8'(chars + 1));
    ad.push_back(tcode);
    repeat (chars) ad.push_back(8'($urandom()));
  endtask

  // random AD payload: names, other fields, zero length, cut-off fields
  task automatic make_ad(ref logic [7:0] ad[$]);
    int nf, r, l;
    nf = $urandom_range(0, 4);
    for (int f = 0; f < nf; f++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        l = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 45) : $urandom_range(0, 12);
        add_name(ad, $urandom_range(0, 1) ? TypeFullName : TypeShortName, l);
      end else if (r < 85) begin
        l = $urandom_range(1, 8);
        ad.push_back(8'(l));
        repeat (l) ad.push_back(8'($urandom()));
      end else if (r < 92) begin
        ad.push_back(8'd0);
        repeat ($urandom_range(0, 3)) ad.push_back(8'($urandom()));
      end else begin
        l = $urandom_range(2, 255);
        ad.push_back(8'(l));
        ad.push_back($urandom_range(0, 1) ? TypeFullName : TypeShortName);
        repeat ($urandom_range(0, (l > 10 ? 10 : l - 2))) ad.push_back(8'($urandom()));
        break;
      end
    end
  endtask

  task automatic test_name_fields();
    logic [7:0] ad[$];
    ad = '{8'd3, TypeFullName, 8'h41, 8'h42};
    send_report('1, 2'd3, 8'h7f, 32'hffff_ffff, ad, 0);
    ad = '{8'd1, TypeShortName};
    send_report(48'h0, 2'd0, 8'h80, 32'h0, ad, 0);
    send_read(0, 1);
    send_read(0, 2);
    send_read(1, 0);
  endtask

  task automatic test_broken_reports();
    logic [7:0] ad[$];
    // zero field length stops the walk before the name
    ad = '{8'd0, 8'd2, TypeFullName, 8'h55};
    send_report(48'h1234_5678_9abc, 2'd1, 8'h10, 32'h1, ad, 0);
    // name field runs past the last byte
    ad = '{8'd9, TypeFullName, 8'hff};
    send_report(48'h5555_aaaa_5555, 2'd2, 8'hf0, 32'h2, ad, 0);
    ad.delete();
    send_report(48'haaaa_5555_aaaa, 2'd1, 8'h01, 32'h3, ad, 0);
    send_beat(rand_beat(CMD_NONE));
    send_read(3, 0);
    send_read(31, 31);
  endtask

  task automatic test_clear();
    logic [7:0] ad[$];
    send_beat(rand_beat(CMD_CLEAR));
    send_read(0, 0);
    ad = '{8'd2, TypeFullName, 8'h7a};
    send_report('1, 2'd0, 8'h00, 32'h55, ad, 0);
    send_read(0, 0);
  endtask

  // overlong report: bytes past the 255th are ignored
  task automatic test_overlong_report();
    logic [7:0] ad[$];
    repeat (50) begin
      ad.push_back(8'd4);
      repeat (4) ad.push_back(8'($urandom()));
    end
    add_name(ad, TypeFullName, 8);
    send_report(pool[47], 2'($urandom()), 8'($urandom()), $urandom(), ad, 0);
    send_read(0, 0);
  endtask

  task automatic test_random_traffic();
    logic [7:0] ad[$];
    int r, start, npool;
    start = items_sent;
    while (items_sent - start < RandItems) begin
      if ($urandom_range(0, 199) == 0) no_gaps = !no_gaps;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        ad.delete();
        make_ad(ad);
        npool = ($urandom_range(0, 3) == 0) ? 48 : 36;
        send_report(pool[$urandom_range(0, npool - 1)], 2'($urandom()), 8'($urandom()),
                    $urandom(), ad, 1);
      end else if (r < 95) begin
        send_read($urandom_range(0, 31), $urandom_range(0, 31));
      end else if (r < 97) begin
        send_beat(rand_beat(CMD_CLEAR));
      end else begin
        send_beat(rand_beat(CMD_NONE));
      end
    end
  endtask

  initial begin
    beat_t idle_b;
    errors = 0; cycles = 0; reports_sent = 0; reads_sent = 0;
    results_seen = 0; items_sent = 0; no_gaps = 0;
    dev_count = 0;
    parse_restart();
    for (int i = 0; i < 48; i++) pool[i] = 48'({$urandom(), $urandom()});
    pool[0] = '1;
    pool[1] = '0;
    rst_n = 0;
    in_valid = 0;
    idle_b = rand_beat(CMD_NONE);
    in_cmd = idle_b.cmd; in_device_address = 0; in_addr_kind = 0;
    in_signal_strength = 0; in_timestamp = 0; in_data_byte = 0;
    in_byte_present = 0; in_report_end = 0; in_entry_select = 0; in_char_select = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_name_fields();
    test_broken_reports();
    test_clear();
    test_overlong_report();
    test_random_traffic();

    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran %0d input beats: %0d reports, %0d table reads, %0d results checked.",
             items_sent, reports_sent, reads_sent, results_seen);
    $display("Covered name parsing, broken fields, table fill, drop, clear and reads.");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
